@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL. They vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge while out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a rising edge while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ hdl/ukcht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ukcht_pkg;

    localparam logic [31:0] HASH_MULT_LO = 32'h7F4A7C15;
    localparam logic [31:0] HASH_MULT_HI = 32'h9E3779B9;
    localparam int          LOAD_NUM     = 3;
    localparam int          LOAD_DEN     = 4;

    localparam logic [1:0] MODE_GET = 2'd0;
    localparam logic [1:0] MODE_SET = 2'd1;
    localparam logic [1:0] MODE_INC = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NEW  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] lookup_key;
        logic [31:0] value_in;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [1:0]  status;
    } out_word_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_READ,
        S_CMP,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

@@ hdl/u64_key_counting_hash_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Counting hash table for 64-bit keys with 32-bit values, open addressing and linear
// probing over TABLE_DEPTH slots (a power of two). After reset the block sweeps the key
// memory clear, one slot a cycle, so it accepts no word until every slot is clear.
// A word is accepted in the idle cycle and then passes S_MUL0, S_MUL1 and S_MUL2 on the
// single shared 32 by 32 multiplier to form the hash, S_SUM to add the partial products,
// S_READ and S_CMP for each slot probed (the key and value memories have a registered
// read port), and S_OUT to hand the result to the output register. A zero key goes from
// idle straight to S_OUT, and S_OUT waits while the previous result still sits in the
// output register. One word is worked on at a time. New keys are refused once three
// quarters of the slots are in use.
module u64_key_counting_hash_table
    import ukcht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] LOAD_LIMIT = CW'((TABLE_DEPTH * LOAD_NUM) / LOAD_DEN);

    state_t          state_reg, state_next;
    in_word_t        req_reg, req_next;
    out_word_t       res_reg, res_next;
    out_word_t       m_data_reg, m_data_next;
    logic            m_valid_reg, m_valid_next;
    logic [63:0]     prod_reg, prod_next;
    logic [31:0]     acc_reg, acc_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   probe_reg, probe_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    logic [31:0]     mul_a, mul_b;
    logic [31:0]     hash_sum;
    logic            key_we, val_we;
    logic [AW-1:0]   key_waddr;
    logic [63:0]     key_wdata;
    logic [31:0]     val_wdata;
    logic [63:0]     key_rdata;
    logic [31:0]     val_rdata;
    logic            is_upd, is_set, slot_empty, slot_match, table_full;

    ukcht_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (key_waddr),
        .wr_data (key_wdata),
        .rd_addr (idx_reg),
        .rd_data (key_rdata)
    );

    ukcht_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_val_ram (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (idx_reg),
        .wr_data (val_wdata),
        .rd_addr (idx_reg),
        .rd_data (val_rdata)
    );

    assign is_set     = (req_reg.mode == MODE_SET);
    assign is_upd     = is_set || (req_reg.mode == MODE_INC);
    assign slot_empty = (key_rdata == 64'd0);
    assign slot_match = (key_rdata == req_reg.lookup_key);
    assign table_full = (cnt_reg >= LOAD_LIMIT);
    assign hash_sum   = acc_reg + prod_reg[31:0];
    assign prod_next  = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb begin
        case (state_reg)
            S_MUL1: begin
                mul_a = req_reg.lookup_key[63:32];
                mul_b = HASH_MULT_LO;
            end
            S_MUL2: begin
                mul_a = req_reg.lookup_key[31:0];
                mul_b = HASH_MULT_HI;
            end
            default: begin
                mul_a = req_reg.lookup_key[31:0];
                mul_b = HASH_MULT_LO;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
            clr_reg     <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        idx_reg    <= idx_next;
        probe_reg  <= probe_next;
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        probe_next   = probe_reg;
        clr_next     = clr_reg;
        cnt_next     = cnt_reg;
        key_we       = 1'b0;
        key_waddr    = idx_reg;
        key_wdata    = req_reg.lookup_key;
        val_we       = 1'b0;
        val_wdata    = 32'd1;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = clr_reg;
                key_wdata = 64'd0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {AW{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next = s_data;
                    if (s_data.lookup_key == 64'd0) begin
                        res_next   = '{found: 1'b0, value_out: 32'd0, status: ST_ZERO};
                        state_next = S_OUT;
                    end else begin
                        state_next = S_MUL0;
                    end
                end
            end
            S_MUL0: begin
                state_next = S_MUL1;
            end
            S_MUL1: begin
                acc_next   = prod_reg[63:32];
                state_next = S_MUL2;
            end
            S_MUL2: begin
                acc_next   = hash_sum;
                state_next = S_SUM;
            end
            S_SUM: begin
                idx_next   = hash_sum[AW-1:0];
                probe_next = '0;
                state_next = S_READ;
            end
            S_READ: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                val_wdata = is_set ? req_reg.value_in : 32'd1;
                if (slot_empty) begin
                    state_next = S_OUT;
                    if (!is_upd) begin
                        res_next = '{found: 1'b0, value_out: 32'd0, status: ST_DONE};
                    end else if (table_full) begin
                        res_next = '{found: 1'b0, value_out: 32'd0, status: ST_FULL};
                    end else begin
                        key_we   = 1'b1;
                        val_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        res_next = '{found: 1'b0, value_out: val_wdata, status: ST_NEW};
                    end
                end else if (slot_match) begin
                    state_next = S_OUT;
                    val_wdata  = is_set ? req_reg.value_in : val_rdata + 32'd1;
                    val_we     = is_upd;
                    res_next   = '{found: 1'b1,
                                   value_out: is_upd ? val_wdata : val_rdata,
                                   status: ST_DONE};
                end else if (probe_reg == {AW{1'b1}}) begin
                    state_next = S_OUT;
                    res_next   = '{found: 1'b0, value_out: 32'd0,
                                   status: is_upd ? ST_FULL : ST_DONE};
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_NEVER(a_count_limit, aclk, aresetn, cnt_reg > LOAD_LIMIT, "Entry count passed the load limit.")
    `ASSERT_NEVER(a_probe_wrap, aclk, aresetn, state_reg == S_CMP && !slot_empty && !slot_match && probe_reg == {AW{1'b1}}, "Probe ran the whole table without an empty slot.")
    `ASSERT_ALWAYS(a_zero_result, aclk, aresetn, (m_valid_reg && m_data_reg.status == ST_ZERO) |-> (!m_data_reg.found && m_data_reg.value_out == 32'd0), "Zero key result carries data.")

endmodule

`default_nettype wire

@@ hdl/ukcht_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ukcht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
